/* sv/lmb_pkg.sv */
// lmb_pkg: shared types and constants for the level meter ballistics block.
// Holds the Q5.16 and Q1.16 formats, register index codes and the coefficient clamp.
// No dependencies.
package lmb_pkg;

  localparam int LEVEL_W   = 21;
  localparam int COEFF_W   = 17;
  localparam int HOLD_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = LEVEL_W + COEFF_W + 1;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COEFF_W-1:0] coeff_t;
  typedef logic [HOLD_W-1:0]  hold_t;
  typedef logic [PROD_W-1:0]  prod_t;

  localparam coeff_t ONE_Q16   = coeff_t'(65536);
  localparam level_t LEVEL_MAX = level_t'(1048576);
  localparam prod_t  ROUND_Q16 = prod_t'(32768);

  localparam coeff_t ATTACK_RST  = coeff_t'(65536);
  localparam coeff_t RELEASE_RST = coeff_t'(13107);
  localparam coeff_t FALL_RST    = coeff_t'(58982);
  localparam hold_t  HOLD_RST    = hold_t'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_RELEASE = 3'd1,
    REG_FALL    = 3'd2,
    REG_HOLD    = 3'd3
  } cfg_reg_t;

  // Any value at or above 1.0 acts as 1.0; bit 16 set means at least 65536.
  function automatic coeff_t clamp_unit(input coeff_t c);
    clamp_unit = c[COEFF_W-1] ? ONE_Q16 : c;
  endfunction

endpackage

/* sv/level_meter_ballistics.sv */
// level_meter_ballistics: smoothed level and held, decaying peak for a meter.
// Depends on lmb_pkg (types, constants, register codes).
//
// Usage:
//   Input channel: in_valid / in_stall with in_target_level, one linear
//   amplitude sample in unsigned Q5.16 per transaction.
//   Result channel: out_valid / out_stall with out_meter_level and
//   out_meter_peak, one result transaction per input transaction.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; write
//   only while the block is idle. cfg_ready is always high. Indexes past the
//   register list are dropped.
// Update and throughput:
//   The whole update (one 17x21 multiply for the level filter, one 21x17
//   multiply for the peak decay, rounding, saturation and compares) runs in
//   the cycle of acceptance; its result is registered into the output
//   register, or into the skid register while the output is held. One sample
//   per cycle is sustained while in_stall is low; the level and peak state loop sets that rate.
// Stall:
//   The result side has an output register and a one-entry skid register.
//   The block keeps taking samples while one finished result waits; in_stall
//   rises only when the skid register is full, and it is a register output.
// Reset:
//   rst_n (synchronous, active low) clears level, peak and hold counter to
//   zero, loads the coefficient defaults and empties both result registers.
module level_meter_ballistics (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lmb_pkg::LEVEL_W-1:0]   in_target_level,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lmb_pkg::LEVEL_W-1:0]   out_meter_level,
  output logic [lmb_pkg::LEVEL_W-1:0]   out_meter_peak,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmb_pkg::CFG_DAT_W-1:0] cfg_data
);

  // configuration registers
  lmb_pkg::coeff_t attack_r, release_r, fall_r;
  lmb_pkg::hold_t  hold_steps_r;

  // meter state
  lmb_pkg::level_t level_r, level_nxt;
  lmb_pkg::level_t peak_r, peak_nxt;
  lmb_pkg::hold_t  hold_cnt_r, hold_cnt_nxt;

  // result registers: output stage and skid stage
  logic            out_vld_r, skid_vld_r;
  lmb_pkg::level_t out_level_r, out_peak_r;
  lmb_pkg::level_t skid_level_r, skid_peak_r;

  logic in_acc, out_take;

  // level filter datapath
  lmb_pkg::coeff_t coeff_sel;
  logic            rising;
  lmb_pkg::level_t diff;
  lmb_pkg::prod_t  lvl_prod;
  logic [lmb_pkg::LEVEL_W:0]   lvl_mag;
  logic [lmb_pkg::LEVEL_W+1:0] lvl_sum;

  // peak datapath
  lmb_pkg::prod_t  pk_prod;
  lmb_pkg::level_t pk_decay;
  lmb_pkg::level_t pk_work;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid && !skid_vld_r;
  assign out_take  = out_vld_r && !out_stall;

  assign out_valid       = out_vld_r;
  assign out_meter_level = out_level_r;
  assign out_meter_peak  = out_peak_r;

  // Level: one-pole step toward the sample, magnitude rounded half away from zero.
  always_comb begin
    rising    = in_target_level > level_r;
    coeff_sel = lmb_pkg::clamp_unit(rising ? attack_r : release_r);
    diff      = (in_target_level >= level_r) ? (in_target_level - level_r)
                                             : (level_r - in_target_level);
    lvl_prod  = lmb_pkg::prod_t'(coeff_sel) * lmb_pkg::prod_t'(diff);
    lvl_mag   = (lmb_pkg::LEVEL_W+1)'((lvl_prod + lmb_pkg::ROUND_Q16) >> lmb_pkg::FRAC_W);
    lvl_sum   = '0;
    if (in_target_level >= level_r) begin
      lvl_sum = (lmb_pkg::LEVEL_W+2)'(level_r) + (lmb_pkg::LEVEL_W+2)'(lvl_mag);
      if (lvl_sum > (lmb_pkg::LEVEL_W+2)'(lmb_pkg::LEVEL_MAX)) begin
        level_nxt = lmb_pkg::LEVEL_MAX;
      end else begin
        level_nxt = lmb_pkg::level_t'(lvl_sum);
      end
    end else begin
      if (lvl_mag > (lmb_pkg::LEVEL_W+1)'(level_r)) begin
        level_nxt = '0;
      end else begin
        level_nxt = level_r - lmb_pkg::level_t'(lvl_mag);
      end
      // a level above 16.0 cannot occur, but keep the clamp for safety
      if (level_nxt > lmb_pkg::LEVEL_MAX) begin
        level_nxt = lmb_pkg::LEVEL_MAX;
      end
    end
  end

  // Peak: reload on a new high, hold while the counter runs, then decay.
  always_comb begin
    pk_prod      = lmb_pkg::prod_t'(peak_r) * lmb_pkg::prod_t'(lmb_pkg::clamp_unit(fall_r));
    pk_decay     = lmb_pkg::level_t'((pk_prod + lmb_pkg::ROUND_Q16) >> lmb_pkg::FRAC_W);
    pk_work      = peak_r;
    hold_cnt_nxt = hold_cnt_r;
    if (in_target_level >= peak_r) begin
      pk_work      = (in_target_level > lmb_pkg::LEVEL_MAX) ? lmb_pkg::LEVEL_MAX
                                                            : in_target_level;
      hold_cnt_nxt = hold_steps_r;
    end else if (hold_cnt_r != '0) begin
      hold_cnt_nxt = hold_cnt_r - lmb_pkg::hold_t'(1);
    end else begin
      pk_work = pk_decay;
    end
    // never leave the peak under the level
    peak_nxt = (pk_work < level_nxt) ? level_nxt : pk_work;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r     <= lmb_pkg::ATTACK_RST;
      release_r    <= lmb_pkg::RELEASE_RST;
      fall_r       <= lmb_pkg::FALL_RST;
      hold_steps_r <= lmb_pkg::HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lmb_pkg::REG_ATTACK:  attack_r     <= cfg_data;
        lmb_pkg::REG_RELEASE: release_r    <= cfg_data;
        lmb_pkg::REG_FALL:    fall_r       <= cfg_data;
        lmb_pkg::REG_HOLD:    hold_steps_r <= cfg_data[lmb_pkg::HOLD_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Meter state: advance on every accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      peak_r     <= '0;
      hold_cnt_r <= '0;
    end else if (in_acc) begin
      level_r    <= level_nxt;
      peak_r     <= peak_nxt;
      hold_cnt_r <= hold_cnt_nxt;
    end
  end

  // Result stages: fill the output register when it is free or draining,
  // otherwise park the new result in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_take) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_take) begin
      if (skid_vld_r) begin
        out_level_r <= skid_level_r;
        out_peak_r  <= skid_peak_r;
      end else if (in_acc) begin
        out_level_r <= level_nxt;
        out_peak_r  <= peak_nxt;
      end
    end else if (in_acc) begin
      skid_level_r <= level_nxt;
      skid_peak_r  <= peak_nxt;
    end
  end

  // The skid stage only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  // The stored level stays within 0..16.0.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= lmb_pkg::LEVEL_MAX)
    else $error("smoothed level above 16.0");

  // The held peak never sits below the level.
  a_peak_above_level: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= level_r)
    else $error("held peak below smoothed level");

  // An accepted sample lands in a result register on the next edge.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_vld_r && out_level_r == level_r) ||
               (skid_vld_r && skid_level_r == level_r))
    else $error("accepted sample did not reach a result register");

endmodule

/* verif/tb_level_meter_ballistics.sv */
// tb_level_meter_ballistics: self-checking bench for the meter level/peak ballistics block.
// A directed table and randomized phases run against a built-in level/peak predictor.
// Depends on lmb_pkg and level_meter_ballistics.
module tb_level_meter_ballistics;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_PAD       = 4;     // output register plus skid entry, with margin
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int PLAN_LEN        = 40;
  localparam lmb_pkg::level_t SAMPLE_MAX = lmb_pkg::level_t'(2097151);

  typedef logic [lmb_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [lmb_pkg::CFG_DAT_W-1:0] cfg_dat_t;

  // Indexes past the register list; the block must drop writes to them.
  localparam cfg_idx_t REG_SPARE_LO = cfg_idx_t'(4);
  localparam cfg_idx_t REG_SPARE_HI = cfg_idx_t'(7);
  // Index column filler for sample rows, where it is unused.
  localparam cfg_idx_t NO_REG       = cfg_idx_t'(0);

  typedef struct packed {
    lmb_pkg::level_t level;
    lmb_pkg::level_t peak;
  } meter_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,   // sample, result from the predictor
    ROW_TYPED,    // sample, result typed into the table
    ROW_CFG       // register write, taken once the block is idle
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    cfg_idx_t        idx;
    lmb_pkg::level_t val;
    lmb_pkg::level_t lvl;
    lmb_pkg::level_t pk;
  } row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  lmb_pkg::level_t in_target_level = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  lmb_pkg::level_t out_meter_level;
  lmb_pkg::level_t out_meter_peak;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  cfg_idx_t        cfg_index = '0;
  cfg_dat_t        cfg_data = '0;

  level_meter_ballistics uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_level (in_target_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_meter_level (out_meter_level),
    .out_meter_peak  (out_meter_peak),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: registers as the block should hold them, plus the
  // smoothed level, held peak and hold countdown.
  lmb_pkg::coeff_t rise_k    = lmb_pkg::ATTACK_RST;
  lmb_pkg::coeff_t drop_k    = lmb_pkg::RELEASE_RST;
  lmb_pkg::coeff_t decay_k   = lmb_pkg::FALL_RST;
  lmb_pkg::hold_t  hold_len  = lmb_pkg::HOLD_RST;
  lmb_pkg::level_t lvl_now   = '0;
  lmb_pkg::level_t pk_now    = '0;
  lmb_pkg::hold_t  hold_left = '0;

  meter_t meter_due[$];   // expected results, oldest first

  int n_err = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit calm = 1'b0;        // no idling on either side
  int env_lvl = 0;        // envelope shape for the random samples

  // Directed plan. Typed results follow from the reset coefficients
  // (attack 1.0, release 0.2, fall 0.9, hold 0) and from the extremes.
  row_t plan [PLAN_LEN] = '{
    // from reset: silence, full scale, release, exactly 16.0, just above
    '{ROW_TYPED,  NO_REG, 21'd0,       21'd0,              21'd0},
    '{ROW_TYPED,  NO_REG, SAMPLE_MAX,  lmb_pkg::LEVEL_MAX, lmb_pkg::LEVEL_MAX},
    '{ROW_TYPED,  NO_REG, 21'd0,       21'd838864,         21'd943712},
    '{ROW_TYPED,  NO_REG, lmb_pkg::LEVEL_MAX, lmb_pkg::LEVEL_MAX, lmb_pkg::LEVEL_MAX},
    '{ROW_TYPED,  NO_REG, 21'd1048577, lmb_pkg::LEVEL_MAX, lmb_pkg::LEVEL_MAX},
    // attack frozen at zero
    '{ROW_CFG,    lmb_pkg::REG_ATTACK,  21'd0,       21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               SAMPLE_MAX,  21'd0, 21'd0},
    // release above 1.0 acts as 1.0: level drops straight to the sample
    '{ROW_CFG,    lmb_pkg::REG_RELEASE, 21'h1FFFF,   21'd0, 21'd0},
    '{ROW_TYPED,  NO_REG,               21'd0,       21'd0, 21'd943712},
    // zero fall factor wipes the peak in one step
    '{ROW_CFG,    lmb_pkg::REG_FALL,    21'd0,       21'd0, 21'd0},
    '{ROW_TYPED,  NO_REG,               21'd0,       21'd0, 21'd0},
    // longest hold; 17-bit write masks to 16 bits
    '{ROW_CFG,    lmb_pkg::REG_ATTACK,  21'd65536,   21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_FALL,    21'd65536,   21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_HOLD,    21'h1FFFF,   21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd65536,   21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd100,     21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd100,     21'd0, 21'd0},
    // writes past the register list are dropped
    '{ROW_CFG,    REG_SPARE_LO,         21'd0,       21'd0, 21'd0},
    '{ROW_CFG,    REG_SPARE_HI,         21'h1FFFF,   21'd0, 21'd0},
    // short hold, then decay
    '{ROW_CFG,    lmb_pkg::REG_HOLD,    21'd2,       21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_RELEASE, 21'd13107,   21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_FALL,    21'd58982,   21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd70000,   21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd0,       21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd0,       21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd0,       21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd0,       21'd0, 21'd0},
    // half coefficients: rounding ties go away from zero both ways
    '{ROW_CFG,    lmb_pkg::REG_ATTACK,  21'd32768,   21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_RELEASE, 21'd65536,   21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd0,       21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_RELEASE, 21'd32768,   21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd1,       21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd0,       21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd3,       21'd0, 21'd0},
    // peak decays below the level and gets pulled back up to it
    '{ROW_CFG,    lmb_pkg::REG_FALL,    21'd0,       21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_HOLD,    21'd0,       21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_RELEASE, 21'd6554,    21'd0, 21'd0},
    '{ROW_CFG,    lmb_pkg::REG_ATTACK,  21'd65536,   21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd1000000, 21'd0, 21'd0},
    '{ROW_SAMPLE, NO_REG,               21'd0,       21'd0, 21'd0}
  };

  // Advance the predicted level and peak by one sample.
  function automatic meter_t meter_next(input lmb_pkg::level_t s);
    lmb_pkg::coeff_t k;
    lmb_pkg::coeff_t f;
    logic [63:0]     mag;
    logic [63:0]     nxt;
    meter_t          r;
    k = (s > lvl_now) ? rise_k : drop_k;
    if (k > lmb_pkg::ONE_Q16) k = lmb_pkg::ONE_Q16;
    // one-pole step, magnitude rounded half away from zero
    if (s >= lvl_now) begin
      mag = (64'(k) * 64'(s - lvl_now) + 64'd32768) >> 16;
      nxt = 64'(lvl_now) + mag;
    end else begin
      mag = (64'(k) * 64'(lvl_now - s) + 64'd32768) >> 16;
      nxt = (mag > 64'(lvl_now)) ? 64'd0 : 64'(lvl_now) - mag;
    end
    if (nxt > 64'(lmb_pkg::LEVEL_MAX)) nxt = 64'(lmb_pkg::LEVEL_MAX);
    lvl_now = lmb_pkg::level_t'(nxt);
    // peak: reload and rearm hold, count hold down, or decay
    if (s >= pk_now) begin
      pk_now = (s > lmb_pkg::LEVEL_MAX) ? lmb_pkg::LEVEL_MAX : s;
      hold_left = hold_len;
    end else if (hold_left != '0) begin
      hold_left = hold_left - lmb_pkg::hold_t'(1);
    end else begin
      f = (decay_k > lmb_pkg::ONE_Q16) ? lmb_pkg::ONE_Q16 : decay_k;
      pk_now = lmb_pkg::level_t'((64'(pk_now) * 64'(f) + 64'd32768) >> 16);
    end
    if (pk_now < lvl_now) pk_now = lvl_now;
    r.level = lvl_now;
    r.peak = pk_now;
    return r;
  endfunction

  // Offer one sample, hold it until taken, queue the expected result.
  task automatic send_sample(input lmb_pkg::level_t s, input bit typed,
                             input lmb_pkg::level_t t_lvl, input lmb_pkg::level_t t_pk);
    meter_t m;
    int     gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_level <= s;
    do @(posedge clk); while (in_stall);
    m = meter_next(s);
    if (typed) begin
      m.level = t_lvl;
      m.peak = t_pk;
    end
    meter_due.push_back(m);
    n_sent++;
  endtask

  // Drop valid and wait until every queued result has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (meter_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input cfg_dat_t dat);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= dat;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lmb_pkg::REG_ATTACK:  rise_k = dat;
      lmb_pkg::REG_RELEASE: drop_k = dat;
      lmb_pkg::REG_FALL:    decay_k = dat;
      lmb_pkg::REG_HOLD:    hold_len = dat[lmb_pkg::HOLD_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coefficient mix: zero, unity, above unity (all ones included), in range.
  function automatic cfg_dat_t pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return cfg_dat_t'(lmb_pkg::ONE_Q16);
      2:       return '1;
      3:       return cfg_dat_t'($urandom_range(65537, 131071));
      default: return cfg_dat_t'($urandom_range(0, 65536));
    endcase
  endfunction

  // Hold lengths: mostly short so decay is reached, sometimes huge or unmasked.
  function automatic cfg_dat_t pick_hold();
    case ($urandom_range(0, 9))
      0:       return cfg_dat_t'(16'hFFFF);
      1:       return cfg_dat_t'($urandom);
      2:       return '0;
      default: return cfg_dat_t'($urandom_range(1, 6));
    endcase
  endfunction

  // Samples: mostly an envelope with occasional hits and smooth decay,
  // the rest noise over the full range, values near the level, silence
  // and the extremes.
  function automatic lmb_pkg::level_t pick_sample();
    int v;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      if ($urandom_range(0, 7) == 0)
        env_lvl = $urandom_range(0, 1200000);
      else
        env_lvl = env_lvl - env_lvl / 8 + $urandom_range(0, 255);
      return lmb_pkg::level_t'(env_lvl);
    end else if (sel < 75) begin
      return lmb_pkg::level_t'($urandom);
    end else if (sel < 85) begin
      v = int'(lvl_now) + $urandom_range(0, 4096) - 2048;
      if (v < 0) v = 0;
      return lmb_pkg::level_t'(v);
    end else if (sel < 95) begin
      return '0;
    end else begin
      case ($urandom_range(0, 2))
        0:       return SAMPLE_MAX;
        1:       return lmb_pkg::LEVEL_MAX;
        default: return lmb_pkg::LEVEL_MAX + lmb_pkg::level_t'($urandom_range(1, 3));
      endcase
    end
  endfunction

  // Result-side stall: random bursts, none when calm.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    meter_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (meter_due.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result: level %0d peak %0d", $time,
                 out_meter_level, out_meter_peak);
      end else begin
        want = meter_due.pop_front();
        n_checked++;
        if (out_meter_level !== want.level) begin
          n_err++;
          $display("%0t: meter_level expected %0d actual %0d", $time,
                   want.level, out_meter_level);
        end
        if (out_meter_peak !== want.peak) begin
          n_err++;
          $display("%0t: meter_peak expected %0d actual %0d", $time,
                   want.peak, out_meter_peak);
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               meter_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table; idling on both sides stays light here.
    in_idle_pct = 20;
    out_idle_pct = 20;
    for (int r = 0; r < PLAN_LEN; r++) begin
      case (plan[r].kind)
        ROW_CFG: begin
          drain();
          cfg_write(plan[r].idx, plan[r].val[lmb_pkg::CFG_DAT_W-1:0]);
        end
        ROW_TYPED:  send_sample(plan[r].val, 1'b1, plan[r].lvl, plan[r].pk);
        default:    send_sample(plan[r].val, 1'b0, '0, '0);
      endcase
    end

    // Random phases: new settings each phase, idle rate varies, and the
    // last phase runs back to back with no idling at all.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      cfg_write(lmb_pkg::REG_ATTACK, pick_coeff());
      cfg_write(lmb_pkg::REG_RELEASE, pick_coeff());
      cfg_write(lmb_pkg::REG_FALL, pick_coeff());
      cfg_write(lmb_pkg::REG_HOLD, pick_hold());
      if ($urandom_range(0, 2) == 0)
        cfg_write(cfg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  cfg_dat_t'($urandom));
      case (ph % 3)
        0: begin
          in_idle_pct = 0;
          out_idle_pct = 40;
        end
        1: begin
          in_idle_pct = 40;
          out_idle_pct = 0;
        end
        default: begin
          in_idle_pct = 25;
          out_idle_pct = 25;
        end
      endcase
      calm = (ph == NUM_PHASES - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_sample(pick_sample(), 1'b0, '0, '0);
    end

    drain();
    $display("run covered %0d samples (%0d directed rows), %0d results checked,",
             n_sent, PLAN_LEN, n_checked);
    $display("  %0d register writes over %0d random phases", n_cfg, NUM_PHASES);
    if (n_err == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
